FILE: sv/ese_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the encoder speed estimator
// Field widths, request and status codes, and the speed scale factor.
// ----------------------------------------------------------------------------
package ese_pkg;

  // Item field widths
  localparam int READ_W  = 12;
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 27;
  localparam int COUNT_W = 2;
  localparam int STAT_W  = 2;

  // Default encoder resolution in bits per turn
  localparam int POS_BITS_DEFAULT = 12;

  // deg/s in Q4 per count per ms: 1000 * 16 * 360 / 256
  localparam int SPEED_SCALE = 22500;
  localparam int SCALE_W     = 15;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STATUS_SPEED   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_READ = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FIRST   = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_CLEARED = 2'd3;

endpackage

FILE: sv/ese_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_sample_if: sample request channel
// Valid/ready channel carrying three position reads and a timestamp.
// ----------------------------------------------------------------------------
interface ese_sample_if import ese_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [READ_W-1:0] read_a;
  logic              read_a_ok;
  logic [READ_W-1:0] read_b;
  logic              read_b_ok;
  logic [READ_W-1:0] read_c;
  logic              read_c_ok;
  logic [TIME_W-1:0] time_ms;

  modport source (
    output valid, req_type, read_a, read_a_ok, read_b, read_b_ok,
           read_c, read_c_ok, time_ms,
    input  ready
  );

  modport sink (
    input  valid, req_type, read_a, read_a_ok, read_b, read_b_ok,
           read_c, read_c_ok, time_ms,
    output ready
  );
endinterface

FILE: sv/ese_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ese_result_if: speed result channel
// Valid/ready channel carrying speed, used position, read count and status.
// ----------------------------------------------------------------------------
interface ese_result_if import ese_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_q4;
  logic [READ_W-1:0]         position_used;
  logic [COUNT_W-1:0]        valid_reads;
  logic [STAT_W-1:0]         status;

  modport source (
    output valid, speed_q4, position_used, valid_reads, status,
    input  ready
  );

  modport sink (
    input  valid, speed_q4, position_used, valid_reads, status,
    output ready
  );
endinterface

FILE: sv/encoder_speed_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_estimator: encoder velocity from median-filtered reads
// Reduces up to three position reads to one, takes the wrapped delta to the
// previous position and divides delta * 22500 by the elapsed milliseconds.
// ----------------------------------------------------------------------------
//  Channel  Dir  Contents
//  req_i    in   req_type, read_a/b/c with ok bits, time_ms
//  rsp_o    out  speed_q4, position_used, valid_reads, status
//
//  A speed item passes from accept to result through a latch step, a
//  reduce/multiply step, NUM_W steps of the restoring divider (one quotient
//  bit each) and a finish step. Clear, empty and first-sample items skip the
//  divider steps. req_i.ready is high only when idle.
//  The result register frees the block while a result waits; a stalled rsp_o
//  holds the finish cycle. Reset clears history, sequencer and result valid.
// ----------------------------------------------------------------------------
module encoder_speed_estimator import ese_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ese_sample_if.sink    req_i,
  ese_result_if.source  rsp_o
);

  localparam int PB     = POSITION_BITS;
  localparam int NUM_W  = PB + SCALE_W;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int DELT_W = PB + 2;

  localparam logic signed [DELT_W-1:0] PosHalf   = DELT_W'(1 << (PB - 1));
  localparam logic signed [DELT_W-1:0] PosCounts = DELT_W'(1 << PB);
  localparam logic [CNT_W-1:0]         CntLast   = CNT_W'(NUM_W - 1);
  localparam logic [31:0]              SpeedPosLim = 32'((1 << (SPEED_W - 1)) - 1);
  localparam logic [31:0]              SpeedNegLim = 32'(1 << (SPEED_W - 1));

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // Latched item
  logic              clr_q;
  logic [PB-1:0]     rd_a_q, rd_b_q, rd_c_q;
  logic              ok_a_q, ok_b_q, ok_c_q;
  logic [TIME_W-1:0] time_q;

  // Working registers
  logic [PB-1:0]      pos_q, pos_d;
  logic [COUNT_W-1:0] nrd_q, nrd_d;
  logic [STAT_W-1:0]  stat_q, stat_d;
  logic               neg_q, neg_d;
  logic [TIME_W-1:0]  dt_q, dt_d;
  logic [TIME_W-1:0]  rem_q, rem_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // History
  logic [PB-1:0]     last_pos_q;
  logic [TIME_W-1:0] last_time_q;
  logic              have_hist_q;

  // Result register
  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] out_speed_q;
  logic [READ_W-1:0]         out_pos_q;
  logic [COUNT_W-1:0]        out_nrd_q;
  logic [STAT_W-1:0]         out_stat_q;

  logic accept, load;

  // Reduce and delta signals
  logic [PB-1:0]           red_pos;
  logic [COUNT_W-1:0]      red_n;
  logic [PB-1:0]           v0, v1;
  logic [PB:0]             pair_sum;
  logic [PB-1:0]           med;
  logic signed [DELT_W-1:0] delta_raw, delta;
  logic [PB-1:0]           delta_mag;
  logic [TIME_W-1:0]       dt_raw;

  // Divider step signals
  logic [TIME_W:0]   rem_sh;
  logic              step_ge;
  logic [TIME_W:0]   rem_sub;

  // Finish signals
  logic [31:0]               quo_ext, mag_lim, mag_sat;
  logic signed [SPEED_W-1:0] speed_fin;

  assign accept = req_i.valid & req_i.ready;
  assign load   = (state_q == S_DONE) & (~out_valid_q | rsp_o.ready);
  assign req_i.ready = (state_q == S_IDLE);

  // Latch the accepted item, reads taken modulo one turn
  always_ff @(posedge clk_i) begin
    if (accept) begin
      clr_q  <= req_i.req_type == REQ_CLEAR;
      rd_a_q <= PB'(req_i.read_a);
      rd_b_q <= PB'(req_i.read_b);
      rd_c_q <= PB'(req_i.read_c);
      ok_a_q <= req_i.read_a_ok;
      ok_b_q <= req_i.read_b_ok;
      ok_c_q <= req_i.read_c_ok;
      time_q <= req_i.time_ms;
    end
  end

  // Reduce valid reads: single, floor average of two, or median of three
  always_comb begin
    red_n = COUNT_W'({1'b0, ok_a_q}) + COUNT_W'({1'b0, ok_b_q})
          + COUNT_W'({1'b0, ok_c_q});
    v0 = ok_a_q ? rd_a_q : (ok_b_q ? rd_b_q : rd_c_q);
    v1 = (ok_a_q & ok_b_q) ? rd_b_q : rd_c_q;
    pair_sum = {1'b0, v0} + {1'b0, v1};
    if (rd_a_q > rd_b_q) begin
      if (rd_b_q > rd_c_q)      med = rd_b_q;
      else if (rd_a_q > rd_c_q) med = rd_c_q;
      else                      med = rd_a_q;
    end else begin
      if (rd_a_q > rd_c_q)      med = rd_a_q;
      else if (rd_b_q > rd_c_q) med = rd_c_q;
      else                      med = rd_b_q;
    end
    unique case (red_n)
      2'd2:    red_pos = pair_sum[PB:1];
      2'd3:    red_pos = med;
      default: red_pos = v0;
    endcase
  end

  // Wrapped shortest delta and elapsed time
  always_comb begin
    delta_raw = $signed({2'b00, red_pos}) - $signed({2'b00, last_pos_q});
    if (delta_raw > PosHalf)       delta = delta_raw - PosCounts;
    else if (delta_raw < -PosHalf) delta = delta_raw + PosCounts;
    else                           delta = delta_raw;
    delta_mag = delta[DELT_W-1] ? PB'(-delta) : PB'(delta);
    dt_raw = time_q - last_time_q;
  end

  // Subtract unit: one restoring division step
  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    step_ge = rem_sh >= {1'b0, dt_q};
    rem_sub = rem_sh - {1'b0, dt_q};
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    nrd_d   = nrd_q;
    stat_d  = stat_q;
    neg_d   = neg_q;
    dt_d    = dt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_PREP;
      end
      S_PREP: begin
        pos_d   = red_pos;
        nrd_d   = red_n;
        neg_d   = delta[DELT_W-1];
        dt_d    = (dt_raw == '0) ? TIME_W'(1) : dt_raw;
        rem_d   = '0;
        quo_d   = NUM_W'(delta_mag) * NUM_W'(SPEED_SCALE);
        cnt_d   = '0;
        state_d = S_DONE;
        priority if (clr_q) begin
          stat_d = STATUS_CLEARED;
          nrd_d  = '0;
          pos_d  = '0;
        end else if (red_n == '0) begin
          stat_d = STATUS_NO_READ;
          pos_d  = '0;
        end else if (!have_hist_q) begin
          stat_d = STATUS_FIRST;
        end else begin
          stat_d  = STATUS_SPEED;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = step_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], step_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CntLast) state_d = S_DONE;
      end
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    nrd_q  <= nrd_d;
    stat_q <= stat_d;
    neg_q  <= neg_d;
    dt_q   <= dt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  // Saturate the quotient and apply the sign
  always_comb begin
    quo_ext   = 32'(quo_q);
    mag_lim   = neg_q ? SpeedNegLim : SpeedPosLim;
    mag_sat   = (quo_ext > mag_lim) ? mag_lim : quo_ext;
    speed_fin = neg_q ? -$signed(SPEED_W'(mag_sat)) : $signed(SPEED_W'(mag_sat));
  end

  // Update history when the result is handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q  <= '0;
      last_time_q <= '0;
      have_hist_q <= 1'b0;
    end else if (load) begin
      if (stat_q == STATUS_CLEARED) begin
        last_pos_q  <= '0;
        last_time_q <= '0;
        have_hist_q <= 1'b0;
      end else if (stat_q != STATUS_NO_READ) begin
        last_pos_q  <= pos_q;
        last_time_q <= time_q;
        have_hist_q <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_speed_q <= (stat_q == STATUS_SPEED) ? speed_fin : '0;
      out_pos_q   <= READ_W'(pos_q);
      out_nrd_q   <= nrd_q;
      out_stat_q  <= stat_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.speed_q4      = out_speed_q;
  assign rsp_o.position_used = out_pos_q;
  assign rsp_o.valid_reads   = out_nrd_q;
  assign rsp_o.status        = out_stat_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request accepted while a previous item is in flight");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dt_q != '0))
    else $error("divider running with zero divisor");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dt_q))
    else $error("partial remainder not below divisor");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !rsp_o.ready) |=> (state_q == S_DONE))
    else $error("result dropped while output register is full");

endmodule
